/* hw/rtl/mlr_pkg.sv */
// Shared types and character codes for the marked line receiver.
package mlr_pkg;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0A;

  // controller -> datapath
  typedef struct packed {
    logic wr_char;     // append in byte to store
    logic clr_count;   // '#' seen
    logic start_drain; // rewind read pointer
    logic emit_char;   // load next stored byte into output register
    logic emit_empty;  // load empty-line marker into output register
  } mlr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_cr;
    logic is_hash;
    logic is_lf;
    logic count_zero;
    logic count_full;
    logic rd_last;     // read pointer at last held byte
    logic slot_free;   // output register free or being taken
  } mlr_sts_t;

endpackage

/* hw/rtl/mlr_ctrl.sv */
// Sequencing state machine for the marked line receiver.
module mlr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  mlr_pkg::mlr_sts_t sts,
  output mlr_pkg::mlr_cmd_t cmd
);
  import mlr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMPTY,
    S_DRAIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   acc;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (sts.is_cr) begin
            // ignored
          end else if (sts.is_hash) begin
            cmd.clr_count = 1'b1;
          end else if (sts.is_lf) begin
            if (sts.count_zero) begin
              state_nxt = S_EMPTY;
            end else begin
              cmd.start_drain = 1'b1;
              state_nxt       = S_DRAIN;
            end
          end else if (!sts.count_full) begin
            cmd.wr_char = 1'b1;
          end
        end
      end
      S_EMPTY: begin
        if (sts.slot_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (sts.slot_free) begin
          cmd.emit_char = 1'b1;
          if (sts.rd_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/mlr_dp.sv */
// Line store, fill count, read pointer and output register.
module mlr_dp #(
  parameter int BUFFER_SIZE = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       in_tdata,
  input  mlr_pkg::mlr_cmd_t cmd,
  output mlr_pkg::mlr_sts_t sts,
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  output logic             out_tuser,
  output logic             out_tvalid,
  input  logic             out_tready
);
  import mlr_pkg::*;

  localparam int STORE_DEPTH = BUFFER_SIZE - 1;
  localparam int CW          = $clog2(BUFFER_SIZE);
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [7:0]    mem [STORE_DEPTH];
  logic [CW-1:0] count_r;
  logic [AW-1:0] ptr_r;
  logic [7:0]    data_r;
  logic          last_r;
  logic          empty_r;
  logic          valid_r;

  assign sts.is_cr      = (in_tdata == CH_CR);
  assign sts.is_hash    = (in_tdata == CH_HASH);
  assign sts.is_lf      = (in_tdata == CH_LF);
  assign sts.count_zero = (count_r == '0);
  assign sts.count_full = (count_r == CW'(STORE_DEPTH));
  assign sts.rd_last    = (CW'(ptr_r) == count_r - CW'(1));
  assign sts.slot_free  = !valid_r || out_tready;

  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = empty_r;
  assign out_tvalid = valid_r;

  // store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_char) begin
      mem[count_r[AW-1:0]] <= in_tdata;
    end
    if (cmd.emit_char) begin
      data_r  <= mem[ptr_r];
      last_r  <= (CW'(ptr_r) == count_r - CW'(1));
      empty_r <= 1'b0;
    end else if (cmd.emit_empty) begin
      data_r  <= '0;
      last_r  <= 1'b1;
      empty_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (cmd.clr_count) begin
        count_r <= '0;
      end else if (cmd.wr_char) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.start_drain) begin
        ptr_r <= '0;
      end else if (cmd.emit_char) begin
        ptr_r <= ptr_r + AW'(1);
      end
      if (cmd.emit_char || cmd.emit_empty) begin
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/marked_line_receiver_top.sv */
// Marked line receiver: top level joining controller and datapath.
//
// Usage: received bytes enter on the in_ stream one word at a time. A carriage
// return is dropped, '#' discards the held line, any other non-line-feed byte
// is appended while fewer than BUFFER_SIZE-1 bytes are held (dropped when full).
// A line feed replays the held bytes on the out_ stream in order, tlast on the
// final one; with nothing held it sends one word with tdata zero and tuser set
// (tlast also set). The held line survives a line feed, so a second line feed
// repeats it.
// After the line feed is accepted the controller enters its drain state and loads
// the first word into the output register from there; words then follow one per
// cycle while out_tready is high, set by the single store read port, and in_tready
// stays low meanwhile. Ordinary bytes are taken one per cycle while in_tready is high.
// Reset (rst_n low, synchronous) empties the line and the output register;
// store contents need no clearing.
// A stalled receiver (out_tready low) holds the output word steady and the
// drain pauses; new input is refused until the whole line has been issued.
module marked_line_receiver_top #(
  parameter int BUFFER_SIZE = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] line_char
  output logic       out_tlast,  // last_char
  output logic       out_tuser   // [0] empty_line
);
  import mlr_pkg::*;

  mlr_cmd_t cmd;
  mlr_sts_t sts;

  mlr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mlr_dp #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

endmodule

/* verif/marked_line_receiver_top_test.sv */
// Self-checking testbench for the marked line receiver: random bursty bytes in, line replay checked.
`timescale 1ns / 100ps

module marked_line_receiver_top_test;
  import mlr_pkg::*;

  localparam int BUFFER_SIZE = 64;
  localparam int STORE_DEPTH = BUFFER_SIZE - 1;
  localparam int RANDOM_ITEMS = 310;
  localparam int IDLE_LIMIT = 2000;   // cycles with no word moving on either side
  localparam int TAIL_CYCLES = 8;

  // one expected output word
  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       empty;
  } line_word_t;

  // Holds its own copy of the line store and fill count, queues the words a
  // line feed should replay and checks the output stream against them.
  class line_scoreboard;
    logic [7:0]  held [STORE_DEPTH];
    int unsigned held_count;
    line_word_t  due_words [$];
    int          errors;
    int          words_checked;
    int          line_feeds;
    int          empty_lines;
    int          full_lines;
    int          dropped_bytes;

    function void note_byte(logic [7:0] b);
      line_word_t w;
      if (b == CH_CR) begin
        return;
      end
      if (b == CH_HASH) begin
        held_count = 0;
        return;
      end
      if (b == CH_LF) begin
        line_feeds++;
        if (held_count == 0) begin
          w.ch = 8'h00;
          w.last = 1'b1;
          w.empty = 1'b1;
          due_words.push_back(w);
          empty_lines++;
          return;
        end
        if (held_count == STORE_DEPTH) full_lines++;
        for (int k = 0; k < held_count; k++) begin
          w.ch = held[k];
          w.last = (k + 1 == held_count);
          w.empty = 1'b0;
          due_words.push_back(w);
        end
        return;
      end
      // ordinary byte: append unless the store is full
      if (held_count < STORE_DEPTH) begin
        held[held_count] = b;
        held_count++;
      end else begin
        dropped_bytes++;
      end
    endfunction

    function void check_word(logic [7:0] data, logic last, logic user);
      line_word_t w;
      if (due_words.size() == 0) begin
        $display("%0t: unexpected word: data=%h last=%b empty=%b", $time, data, last, user);
        errors++;
        return;
      end
      w = due_words.pop_front();
      words_checked++;
      if (data !== w.ch) begin
        $display("%0t: line_char mismatch: expected %h, got %h", $time, w.ch, data);
        errors++;
      end
      if (last !== w.last) begin
        $display("%0t: last_char mismatch: expected %b, got %b", $time, w.last, last);
        errors++;
      end
      if (user !== w.empty) begin
        $display("%0t: empty_line mismatch: expected %b, got %b", $time, w.empty, user);
        errors++;
      end
    endfunction

    function int pending();
      return due_words.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  line_scoreboard sb = new();

  int burst_left = 0;
  int bytes_sent = 0;      // bytes that count towards the random quota
  int idle_cycles = 0;
  int lines_sent = 0;

  marked_line_receiver_top #(.BUFFER_SIZE(BUFFER_SIZE)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure: a rotating 8-bit ready pattern, reloaded now and
  // then; sometimes all ones so long stretches run without stalls.
  logic [7:0] ready_pattern = 8'hFF;
  int         ready_phase = 0;
  always @(posedge clk) begin
    if (ready_phase == 47) begin
      ready_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
      ready_phase <= 0;
    end else begin
      ready_phase <= ready_phase + 1;
    end
    out_tready <= rst_n & ready_pattern[ready_phase % 8];
  end

  // Sample at the falling edge: the values seen here are those the next
  // rising edge will accept, free of any ordering within the edge itself.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_word(out_tdata, out_tlast, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: watchdog: no word moved for %0d cycles", $time, IDLE_LIMIT);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Offer one byte and return on the edge that accepts it. Gaps between
  // bursts only lower tvalid when there really is a gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    sb.note_byte(b);
    if (b != CH_CR) bytes_sent++;
  endtask

  // Hold off the sender until every queued word has come out.
  task automatic wait_line_out();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // One random line: content, the odd CR, noise or stray '#', then LF,
  // sometimes a repeated LF, mostly a '#' to start afresh.
  task automatic send_line(input int len);
    int roll;
    logic [7:0] b;
    for (int k = 0; k < len; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        b = CH_CR;
      end else if (roll < 6) begin
        b = CH_HASH;
      end else if (roll < 12) begin
        b = 8'($urandom_range(0, 255));
      end else begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_HASH || b == CH_LF);
      end
      send_byte(b);
    end
    send_byte(CH_LF);
    if ($urandom_range(0, 4) == 0) send_byte(CH_LF);
    if ($urandom_range(0, 9) < 7) send_byte(CH_HASH);
  endtask

  initial begin
    int len;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty line, CR handling, extreme bytes, repeat, clear
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h41);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_LF);
    send_byte(CH_HASH);
    send_byte(CH_LF);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(CH_HASH);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(CH_LF);
    send_byte(CH_HASH);
    send_byte(CH_CR);
    send_byte(CH_LF);
    wait_line_out();

    // random lines; line index 3 is given 66 bytes, more than the store holds
    bytes_sent = 0;
    while (bytes_sent < RANDOM_ITEMS) begin
      if (lines_sent == 3) len = 66;
      else if ($urandom_range(0, 15) == 0) len = $urandom_range(58, 70);
      else len = $urandom_range(0, 12);
      send_line(len);
      lines_sent++;
      if (lines_sent % 12 == 0) wait_line_out();
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d random bytes in %0d lines; %0d line feeds, %0d empty lines.",
             bytes_sent, lines_sent, sb.line_feeds, sb.empty_lines);
    $display("Checked %0d words; %0d full-store replays, %0d bytes dropped when full.",
             sb.words_checked, sb.full_lines, sb.dropped_bytes);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
